// ===== design/vmda_pkg.sv =====
// ----------------------------------------------------------------------------
// vmda_pkg: shared types, constants and helpers
// Fixed-point word type, rounding multiply, sine polynomial and square-root
// constants, and the register map of the configuration port.
// ----------------------------------------------------------------------------
package vmda_pkg;

  // Signed Q2.30 working word with headroom for sums of several terms.
  localparam int unsigned SigW = 36;
  typedef logic signed [SigW-1:0] sig_t;

  localparam sig_t ONE_Q30   = sig_t'(64'sd1073741824);
  localparam sig_t HALF_Q30  = sig_t'(64'sd536870912);
  localparam sig_t SQRT2_Q30 = sig_t'(64'sd1518500250);
  localparam sig_t SCALE_Q30 = sig_t'(64'sd256336979);

  // Quarter-wave sine polynomial coefficients, Q1.15.
  localparam logic [15:0] SIN_A = 16'd51472;
  localparam logic [15:0] SIN_B = 16'd21024;
  localparam logic [15:0] SIN_C = 16'd2320;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  // Square root unit geometry.
  localparam int unsigned MagW        = 30;
  localparam int unsigned RootW       = MagW / 2;
  localparam int unsigned RemW        = RootW + 3;
  localparam int unsigned SqrtStages  = 5;
  localparam int unsigned StepsPerStg = RootW / SqrtStages;

  // Configuration register map.
  typedef enum logic [2:0] {
    REG_RHO_0_00   = 3'd0,
    REG_RHO_0_10   = 3'd1,
    REG_RHO_0_1M1  = 3'd2,
    REG_RHO_1_11   = 3'd3,
    REG_RHO_1_00   = 3'd4,
    REG_RHO_1_10   = 3'd5,
    REG_RHO_1_1M1  = 3'd6,
    REG_RHO_2_PAIR = 3'd7
  } cfg_reg_e;

  // Q2.30 product rounded to nearest, halves away from zero.
  function automatic sig_t mulq(sig_t a, sig_t b);
    logic signed [2*SigW-1:0] p;
    logic [2*SigW-1:0] m;
    sig_t r;
    p = a * b;
    m = p[2*SigW-1] ? (2*SigW)'(-p) : (2*SigW)'(p);
    m = m + ((2*SigW)'(1) << 29);
    r = sig_t'(m >> 30);
    return p[2*SigW-1] ? -r : r;
  endfunction

endpackage

// ===== design/vmda_sine.sv =====
// ----------------------------------------------------------------------------
// vmda_sine: pipelined sine of a 16-bit turn angle
// Four register stages: quarter-wave folding and t squared, then the three
// Horner steps of the polynomial; the result is signed Q2.30.
// ----------------------------------------------------------------------------
module vmda_sine (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [15:0]         angle_i,
  output vmda_pkg::sig_t      sine_o
);

  localparam logic [15:0] SIN_C_EXT = vmda_pkg::SIN_C;

  logic [1:0]  quad;
  logic [15:0] t_base, t;
  logic [31:0] tt;

  logic [15:0] t_a_q, t2_a_q, t_b_q, t2_b_q, r1_b_q, t_c_q, r2_c_q;
  logic        neg_a_q, neg_b_q, neg_c_q;
  logic [31:0] c_prod, r1_prod, r2_prod;
  logic [15:0] r1_d, r2_d, s_d;
  vmda_pkg::sig_t sine_d, sine_q;

  always_comb begin
    quad   = angle_i[15:14];
    t_base = {1'b0, angle_i[13:0], 1'b0};
    t      = quad[0] ? (16'd32768 - t_base) : t_base;
    tt     = t * t;
  end

  always_comb begin
    c_prod  = SIN_C_EXT * t2_a_q;
    r1_d    = vmda_pkg::SIN_B - c_prod[30:15];
    r1_prod = r1_b_q * t2_b_q;
    r2_d    = vmda_pkg::SIN_A - r1_prod[30:15];
    r2_prod = r2_c_q * t_c_q;
    s_d     = r2_prod[30:15];
    sine_d  = vmda_pkg::sig_t'({5'd0, s_d, 15'd0});
    if (neg_c_q) begin
      sine_d = -sine_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_a_q   <= t;
      t2_a_q  <= tt[30:15];
      neg_a_q <= quad[1];
      t_b_q   <= t_a_q;
      t2_b_q  <= t2_a_q;
      r1_b_q  <= r1_d;
      neg_b_q <= neg_a_q;
      t_c_q   <= t_b_q;
      r2_c_q  <= r2_d;
      neg_c_q <= neg_b_q;
      sine_q  <= sine_d;
    end
  end

  assign sine_o = sine_q;

endmodule

// ===== design/vmda_sqrt.sv =====
// ----------------------------------------------------------------------------
// vmda_sqrt: pipelined integer square root
// Digit-by-digit restoring root, a few result bits per register stage, with
// a one-bit tag carried alongside.
// ----------------------------------------------------------------------------
module vmda_sqrt (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [vmda_pkg::MagW-1:0]       rad_i,
  input  logic                            tag_i,
  output logic [vmda_pkg::RootW-1:0]      root_o,
  output logic                            tag_o
);

  localparam int unsigned MW = vmda_pkg::MagW;
  localparam int unsigned RW = vmda_pkg::RootW;
  localparam int unsigned EW = vmda_pkg::RemW;
  localparam int unsigned NS = vmda_pkg::SqrtStages;
  localparam int unsigned KS = vmda_pkg::StepsPerStg;

  logic [MW-1:0] x_q    [NS];
  logic [EW-1:0] rem_q  [NS];
  logic [RW-1:0] root_q [NS];
  logic          tag_q  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [MW-1:0] x_in;
    logic [EW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic          tag_in;
    logic [MW-1:0] x_d;
    logic [EW-1:0] rem_d, trial, shifted;
    logic [RW-1:0] root_d;

    if (s == 0) begin : g_first
      assign x_in    = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign x_in    = x_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign tag_in  = tag_q[s-1];
    end

    always_comb begin
      x_d    = x_in;
      rem_d  = rem_in;
      root_d = root_in;
      for (int k = 0; k < KS; k++) begin
        shifted = {rem_d[EW-3:0], x_d[MW-1:MW-2]};
        x_d     = x_d << 2;
        trial   = EW'({root_d, 2'b01});
        if (shifted >= trial) begin
          rem_d  = shifted - trial;
          root_d = {root_d[RW-2:0], 1'b1};
        end else begin
          rem_d  = shifted;
          root_d = {root_d[RW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s]    <= x_d;
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        tag_q[s]  <= tag_in;
      end
    end
  end

  assign root_o = root_q[NS-1];
  assign tag_o  = tag_q[NS-1];

endmodule

// ===== design/vector_meson_decay_angle_amplitude.sv =====
// ----------------------------------------------------------------------------
// vector_meson_decay_angle_amplitude: polarized vector-meson decay weight
// Evaluates the angular distribution W from nine spin-density elements and
// the decay angles of one event, scales it by 3/(4 pi) and returns the
// square root of its magnitude with a sign flag.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload (lowest bit first)                 Handshake
//  s_axis    in         cos_theta, sin_sq_theta, sin_two_theta,    tvalid/tready
//                       decay_phi, pol_phi, pol_degree
//  m_axis    out        tdata: amplitude; tuser: w_negative        tvalid/tready
//  cfg       in         register index and write data              cfg_we_i
//
// One request enters per cycle unless the pipeline halts. The pipeline has
// 16 register stages. Stage 1 unpacks the request, stages 2 to 10 hold
// rounding multiplies or short sums (stage 5 waits; the sine polynomials
// run alongside in stages 2 to 5), stage 11 takes the magnitude and stages
// 12 to 16 are the square root unit. The whole pipeline advances together
// and halts when the output register holds a result not yet taken.
// Reset clears the valid bits and the configuration registers to zero.
//
module vector_meson_decay_angle_amplitude #(
  parameter int unsigned FRACTION_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cos_theta[15:0], sin_sq_theta[30:16], sin_two_theta[46:31],
  // decay_phi[62:47], pol_phi[78:63], pol_degree[94:79], zero pad[95]
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // amplitude[15:0]
  output logic [15:0] m_axis_tdata,
  // w_negative[0]
  output logic        m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned Shift  = 30 - FRACTION_BITS;
  localparam int unsigned Stages = 16;
  localparam int unsigned W      = vmda_pkg::SigW;

  // Converts a raw fraction to Q2.30 and clamps it to magnitude one.
  function automatic vmda_pkg::sig_t conv(logic signed [16:0] raw);
    vmda_pkg::sig_t v;
    v = vmda_pkg::sig_t'(raw) <<< Shift;
    if (v > vmda_pkg::ONE_Q30) begin
      v = vmda_pkg::ONE_Q30;
    end
    if (v < -vmda_pkg::ONE_Q30) begin
      v = -vmda_pkg::ONE_Q30;
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [15:0] rho_q [7];
  logic [31:0] rho2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 7; i++) begin
        rho_q[i] <= '0;
      end
      rho2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (vmda_pkg::cfg_reg_e'(cfg_idx_i))
        vmda_pkg::REG_RHO_0_00:   rho_q[0] <= cfg_data_i[15:0];
        vmda_pkg::REG_RHO_0_10:   rho_q[1] <= cfg_data_i[15:0];
        vmda_pkg::REG_RHO_0_1M1:  rho_q[2] <= cfg_data_i[15:0];
        vmda_pkg::REG_RHO_1_11:   rho_q[3] <= cfg_data_i[15:0];
        vmda_pkg::REG_RHO_1_00:   rho_q[4] <= cfg_data_i[15:0];
        vmda_pkg::REG_RHO_1_10:   rho_q[5] <= cfg_data_i[15:0];
        vmda_pkg::REG_RHO_1_1M1:  rho_q[6] <= cfg_data_i[15:0];
        vmda_pkg::REG_RHO_2_PAIR: rho2_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  vmda_pkg::sig_t r000, r010, r01m1, r111, r100, r110, r11m1, i210, i21m1;

  always_comb begin
    r000  = conv(17'(signed'(rho_q[0])));
    r010  = conv(17'(signed'(rho_q[1])));
    r01m1 = conv(17'(signed'(rho_q[2])));
    r111  = conv(17'(signed'(rho_q[3])));
    r100  = conv(17'(signed'(rho_q[4])));
    r110  = conv(17'(signed'(rho_q[5])));
    r11m1 = conv(17'(signed'(rho_q[6])));
    i210  = conv(17'(signed'(rho2_q[31:16])));
    i21m1 = conv(17'(signed'(rho2_q[15:0])));
  end

  // Products of configuration values alone. The user must change them only
  // while the block is idle (not enforced), so these settle before use.
  vmda_pkg::sig_t k0_q, k1_q, a010_q, a110_q, a210_q;

  always_ff @(posedge clk_i) begin
    k0_q   <= vmda_pkg::mulq(vmda_pkg::HALF_Q30, vmda_pkg::ONE_Q30 - r000);
    k1_q   <= vmda_pkg::mulq(vmda_pkg::HALF_Q30, 3 * r000 - vmda_pkg::ONE_Q30);
    a010_q <= vmda_pkg::mulq(vmda_pkg::SQRT2_Q30, r010);
    a110_q <= vmda_pkg::mulq(vmda_pkg::SQRT2_Q30, r110);
    a210_q <= vmda_pkg::mulq(vmda_pkg::SQRT2_Q30, i210);
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: every stage moves together unless the output holds.
  // ---------------------------------------------------------------------------
  logic              en;
  logic [Stages:1]   v_q;

  assign en            = !v_q[Stages] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[Stages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Stages-1:1], s_axis_tvalid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: unpack and convert the request.
  // ---------------------------------------------------------------------------
  vmda_pkg::sig_t ct1_q, ss1_q, s2t1_q, pg1_q;
  logic [15:0]    ph1_q, bp1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ct1_q  <= conv(17'(signed'(s_axis_tdata[15:0])));
      ss1_q  <= conv(signed'({2'b00, s_axis_tdata[30:16]}));
      s2t1_q <= conv(17'(signed'(s_axis_tdata[46:31])));
      ph1_q  <= s_axis_tdata[62:47];
      bp1_q  <= s_axis_tdata[78:63];
      pg1_q  <= vmda_pkg::sig_t'({s_axis_tdata[94:79], 14'd0});
    end
  end

  // Six sines of the azimuths, ready at stage 5.
  vmda_pkg::sig_t cp5, sp5, c2p5, s2p5, c2b5, s2b5;
  logic [15:0] ph2, bp2;

  assign ph2 = {ph1_q[14:0], 1'b0};
  assign bp2 = {bp1_q[14:0], 1'b0};

  vmda_sine u_cp  (.clk_i, .en_i(en), .angle_i(ph1_q + vmda_pkg::QUARTER_TURN), .sine_o(cp5));
  vmda_sine u_sp  (.clk_i, .en_i(en), .angle_i(ph1_q), .sine_o(sp5));
  vmda_sine u_c2p (.clk_i, .en_i(en), .angle_i(ph2 + vmda_pkg::QUARTER_TURN), .sine_o(c2p5));
  vmda_sine u_s2p (.clk_i, .en_i(en), .angle_i(ph2), .sine_o(s2p5));
  vmda_sine u_c2b (.clk_i, .en_i(en), .angle_i(bp2 + vmda_pkg::QUARTER_TURN), .sine_o(c2b5));
  vmda_sine u_s2b (.clk_i, .en_i(en), .angle_i(bp2), .sine_o(s2b5));

  // ---------------------------------------------------------------------------
  // Stages 2 to 11: the weight itself.
  // ---------------------------------------------------------------------------
  vmda_pkg::sig_t c2_2_q, ss2_q, s2t2_q, pg2_q;
  vmda_pkg::sig_t p1_3_q, p2_3_q, p3_3_q, p4_3_q, p5_3_q, p6_3_q, p7_3_q, p8_3_q, p9_3_q;
  vmda_pkg::sig_t pg3_q;
  vmda_pkg::sig_t w0_4_q, p2_4_q, p3_4_q, p4_4_q, p5_4_q, p6_4_q, p7_4_q, p8_4_q, p9_4_q;
  vmda_pkg::sig_t pg4_q;
  vmda_pkg::sig_t w0_5_q, p2_5_q, p3_5_q, p4_5_q, p5_5_q, p6_5_q, p7_5_q, p8_5_q, p9_5_q;
  vmda_pkg::sig_t pg5_q;
  vmda_pkg::sig_t w0_6_q, p4_6_q, p5_6_q, q2_6_q, q3_6_q, q6_6_q, q7_6_q, q8_6_q, q9_6_q;
  vmda_pkg::sig_t g1_6_q, g2_6_q;
  vmda_pkg::sig_t w1_7_q, b1_7_q, b2_7_q, g1_7_q, g2_7_q;
  vmda_pkg::sig_t w1_8_q, m1_8_q, m2_8_q;
  vmda_pkg::sig_t w_9_q, ws_10_q;
  logic [vmda_pkg::MagW-1:0] mag_11_q;
  logic                      neg_11_q;
  logic [W-1:0]              mag_abs;

  assign mag_abs = ws_10_q[W-1] ? W'(-ws_10_q) : W'(ws_10_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Stage 2: cos squared.
      c2_2_q <= vmda_pkg::mulq(ct1_q, ct1_q);
      ss2_q  <= ss1_q;
      s2t2_q <= s2t1_q;
      pg2_q  <= pg1_q;
      // Stage 3: element-by-angle products.
      p1_3_q <= vmda_pkg::mulq(k1_q, c2_2_q);
      p2_3_q <= vmda_pkg::mulq(a010_q, s2t2_q);
      p3_3_q <= vmda_pkg::mulq(r01m1, ss2_q);
      p4_3_q <= vmda_pkg::mulq(r111, ss2_q);
      p5_3_q <= vmda_pkg::mulq(r100, c2_2_q);
      p6_3_q <= vmda_pkg::mulq(a110_q, s2t2_q);
      p7_3_q <= vmda_pkg::mulq(r11m1, ss2_q);
      p8_3_q <= vmda_pkg::mulq(a210_q, s2t2_q);
      p9_3_q <= vmda_pkg::mulq(i21m1, ss2_q);
      pg3_q  <= pg2_q;
      // Stage 4: constant part of the unpolarized term.
      w0_4_q <= k0_q + p1_3_q;
      p2_4_q <= p2_3_q;
      p3_4_q <= p3_3_q;
      p4_4_q <= p4_3_q;
      p5_4_q <= p5_3_q;
      p6_4_q <= p6_3_q;
      p7_4_q <= p7_3_q;
      p8_4_q <= p8_3_q;
      p9_4_q <= p9_3_q;
      pg4_q  <= pg3_q;
      // Stage 5: wait for the sines.
      w0_5_q <= w0_4_q;
      p2_5_q <= p2_4_q;
      p3_5_q <= p3_4_q;
      p4_5_q <= p4_4_q;
      p5_5_q <= p5_4_q;
      p6_5_q <= p6_4_q;
      p7_5_q <= p7_4_q;
      p8_5_q <= p8_4_q;
      p9_5_q <= p9_4_q;
      pg5_q  <= pg4_q;
      // Stage 6: azimuthal factors and polarization weights.
      w0_6_q <= w0_5_q;
      p4_6_q <= p4_5_q;
      p5_6_q <= p5_5_q;
      q2_6_q <= vmda_pkg::mulq(p2_5_q, cp5);
      q3_6_q <= vmda_pkg::mulq(p3_5_q, c2p5);
      q6_6_q <= vmda_pkg::mulq(p6_5_q, cp5);
      q7_6_q <= vmda_pkg::mulq(p7_5_q, c2p5);
      q8_6_q <= vmda_pkg::mulq(p8_5_q, sp5);
      q9_6_q <= vmda_pkg::mulq(p9_5_q, s2p5);
      g1_6_q <= vmda_pkg::mulq(pg5_q, c2b5);
      g2_6_q <= vmda_pkg::mulq(pg5_q, s2b5);
      // Stage 7: the three brackets.
      w1_7_q <= w0_6_q - q2_6_q - q3_6_q;
      b1_7_q <= p4_6_q + p5_6_q - q6_6_q - q7_6_q;
      b2_7_q <= q8_6_q + q9_6_q;
      g1_7_q <= g1_6_q;
      g2_7_q <= g2_6_q;
      // Stage 8: polarized contributions.
      w1_8_q <= w1_7_q;
      m1_8_q <= vmda_pkg::mulq(g1_7_q, b1_7_q);
      m2_8_q <= vmda_pkg::mulq(g2_7_q, b2_7_q);
      // Stage 9: full weight.
      w_9_q  <= w1_8_q - m1_8_q - m2_8_q;
      // Stage 10: normalization by 3/(4 pi).
      ws_10_q <= vmda_pkg::mulq(w_9_q, vmda_pkg::SCALE_Q30);
      // Stage 11: magnitude in Q6.24 steps for a Q3.12 root.
      mag_11_q <= mag_abs[vmda_pkg::MagW+5:6];
      neg_11_q <= ws_10_q[W-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 12 to 16: square root; its last stage is the output register.
  // ---------------------------------------------------------------------------
  logic [vmda_pkg::RootW-1:0] root;

  vmda_sqrt u_sqrt (
    .clk_i,
    .en_i   (en),
    .rad_i  (mag_11_q),
    .tag_i  (neg_11_q),
    .root_o (root),
    .tag_o  (m_axis_tuser)
  );

  // The root of a 30-bit value never exceeds the 16-bit output range.
  assign m_axis_tdata = 16'(root);

endmodule

// ===== dv/vector_meson_decay_angle_amplitude_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_meson_decay_angle_amplitude_test: self-checking stream testbench
// Streams decay-angle events through the block under several spin-density
// settings and compares each amplitude and sign flag with a bit-exact
// fixed-point prediction of the angular distribution.
// ----------------------------------------------------------------------------
module vector_meson_decay_angle_amplitude_test;

  localparam int unsigned FracBits   = 15;
  localparam int unsigned RandItems  = 290;   // per configuration phase
  localparam int unsigned NumPhases  = 7;
  localparam int unsigned DrainWait  = 24;    // pipeline is 16 deep
  localparam int unsigned StallLimit = 20000;

  // One event as it travels on the input stream.
  typedef struct packed {
    logic [15:0] pol_degree;
    logic [15:0] pol_phi;
    logic [15:0] decay_phi;
    logic [15:0] sin_two_theta;
    logic [14:0] sin_sq_theta;
    logic [15:0] cos_theta;
  } event_t;

  typedef struct packed {
    logic [15:0] amplitude;
    logic        w_negative;
  } weight_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  always #1 clk_i = ~clk_i;

  vector_meson_decay_angle_amplitude #(.FRACTION_BITS(FracBits)) u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Shadow copy of the spin-density registers as the block should hold them.
  logic [31:0] rho_regs [8];

  event_t  event_queue [$];     // events waiting to be offered
  weight_t weight_queue [$];    // predicted results, oldest first
  event_t  event_on_bus;
  int unsigned events_sent = 0;
  int unsigned weights_seen = 0;
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // ---------------------------------------------------------------------------
  // Fixed-point predictor. Everything is carried as signed Q2.30 in 64 bits.
  // ---------------------------------------------------------------------------
  function automatic longint to_q30(longint raw);
    longint v;
    v = raw * (longint'(1) << (30 - FracBits));
    if (v > (longint'(1) << 30)) v = longint'(1) << 30;
    if (v < -(longint'(1) << 30)) v = -(longint'(1) << 30);
    return v;
  endfunction

  // Rounded Q2.30 product, halves away from zero.
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    if (p >= 0) return (p + (longint'(1) << 29)) >>> 30;
    return -((-p + (longint'(1) << 29)) >>> 30);
  endfunction

  // Quarter-wave sine polynomial, all terms non-negative and truncated.
  function automatic longint quarter_wave(longint t);
    longint t2, r;
    t2 = (t * t) >> 15;
    r  = (longint'(vmda_pkg::SIN_C) * t2) >> 15;
    r  = longint'(vmda_pkg::SIN_B) - r;
    r  = (r * t2) >> 15;
    r  = longint'(vmda_pkg::SIN_A) - r;
    return (r * t) >> 15;
  endfunction

  function automatic longint turn_sine(logic [15:0] a);
    longint t, s;
    t = longint'({a[13:0], 1'b0});
    if (a[14]) t = 32768 - t;
    s = quarter_wave(t) * 32768;
    return a[15] ? -s : s;
  endfunction

  function automatic longint turn_cosine(logic [15:0] a);
    return turn_sine(a + vmda_pkg::QUARTER_TURN);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic weight_t predict_weight(event_t ev);
    longint one, half, r000, r010, r01m1, r111, r100, r110, r11m1, i210, i21m1;
    longint ct, ss, s2t, pg, c2, cp, sp, c2p, s2p, c2b, s2b, w, b1, b2;
    longint unsigned mag, amp;
    logic [15:0] ph2, bp2;
    weight_t res;
    one   = longint'(1) << 30;
    half  = longint'(1) << 29;
    r000  = to_q30(longint'($signed(rho_regs[vmda_pkg::REG_RHO_0_00][15:0])));
    r010  = to_q30(longint'($signed(rho_regs[vmda_pkg::REG_RHO_0_10][15:0])));
    r01m1 = to_q30(longint'($signed(rho_regs[vmda_pkg::REG_RHO_0_1M1][15:0])));
    r111  = to_q30(longint'($signed(rho_regs[vmda_pkg::REG_RHO_1_11][15:0])));
    r100  = to_q30(longint'($signed(rho_regs[vmda_pkg::REG_RHO_1_00][15:0])));
    r110  = to_q30(longint'($signed(rho_regs[vmda_pkg::REG_RHO_1_10][15:0])));
    r11m1 = to_q30(longint'($signed(rho_regs[vmda_pkg::REG_RHO_1_1M1][15:0])));
    i210  = to_q30(longint'($signed(rho_regs[vmda_pkg::REG_RHO_2_PAIR][31:16])));
    i21m1 = to_q30(longint'($signed(rho_regs[vmda_pkg::REG_RHO_2_PAIR][15:0])));
    ct  = to_q30(longint'($signed(ev.cos_theta)));
    ss  = to_q30(longint'(ev.sin_sq_theta));
    s2t = to_q30(longint'($signed(ev.sin_two_theta)));
    pg  = longint'(ev.pol_degree) * (longint'(1) << 14);
    ph2 = {ev.decay_phi[14:0], 1'b0};
    bp2 = {ev.pol_phi[14:0], 1'b0};
    c2  = qmul(ct, ct);
    cp  = turn_cosine(ev.decay_phi);
    sp  = turn_sine(ev.decay_phi);
    c2p = turn_cosine(ph2);
    s2p = turn_sine(ph2);
    c2b = turn_cosine(bp2);
    s2b = turn_sine(bp2);
    w = qmul(half, one - r000)
      + qmul(qmul(half, 3 * r000 - one), c2)
      - qmul(qmul(qmul(longint'(vmda_pkg::SQRT2_Q30), r010), s2t), cp)
      - qmul(qmul(r01m1, ss), c2p);
    b1 = qmul(r111, ss) + qmul(r100, c2)
       - qmul(qmul(qmul(longint'(vmda_pkg::SQRT2_Q30), r110), s2t), cp)
       - qmul(qmul(r11m1, ss), c2p);
    w = w - qmul(qmul(pg, c2b), b1);
    b2 = qmul(qmul(qmul(longint'(vmda_pkg::SQRT2_Q30), i210), s2t), sp)
       + qmul(qmul(i21m1, ss), s2p);
    w = w - qmul(qmul(pg, s2b), b2);
    w = qmul(w, longint'(vmda_pkg::SCALE_Q30));
    mag = (w < 0) ? longint'(-w) : longint'(w);
    amp = int_sqrt(mag >> 6);
    if (amp > 65535) amp = 65535;
    res.amplitude  = amp[15:0];
    res.w_negative = (w < 0);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued events, holding each one until it is taken. The
  // prediction is made at the edge where the request is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic   hold;
    event_t nxt;
    hold = s_axis_tvalid && !s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) begin
      weight_queue.push_back(predict_weight(event_on_bus));
    end
    if (rst_ni && !hold) begin
      if (event_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = event_queue.pop_front();
        event_on_bus  <= nxt;
        s_axis_tdata  <= {1'b0, nxt};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each taken result against the oldest prediction and
  // stalls the result stream at random.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    $display("[%0t] result %0d: %s got %0d expected %0d",
             $realtime, weights_seen, what, got, want);
  endtask

  always @(posedge clk_i) begin
    weight_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (weight_queue.size() == 0) begin
        report_mismatch("unexpected result, amplitude", m_axis_tdata, 0);
      end else begin
        want = weight_queue.pop_front();
        if (m_axis_tdata !== want.amplitude)
          report_mismatch("amplitude", m_axis_tdata, want.amplitude);
        if (m_axis_tuser !== want.w_negative)
          report_mismatch("w_negative", m_axis_tuser, want.w_negative);
      end
      weights_seen <= weights_seen + 1;
    end
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles without any accepted request or result.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("** vector_meson_decay_angle_amplitude: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Mostly uniform values, with the corners of a signed 16-bit word mixed in.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_reg(input vmda_pkg::cfg_reg_e idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    rho_regs[idx] = (idx == vmda_pkg::REG_RHO_2_PAIR) ? data : {16'h0, data[15:0]};
  endtask

  // Writes every register; mode 0 zero, 1 all maximum, 2 all minimum,
  // otherwise random words (upper bits of the short registers random too).
  task automatic load_rho(input int mode);
    logic [31:0] v;
    for (int i = 0; i < 8; i++) begin
      case (mode)
        0: v = 32'h0000_0000;
        1: v = (i == 7) ? 32'h7FFF_7FFF : 32'hFFFF_7FFF;
        2: v = (i == 7) ? 32'h8000_8000 : 32'h0000_8000;
        default: v = {pick_word(), pick_word()};
      endcase
      write_reg(vmda_pkg::cfg_reg_e'(i), v);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_event(input logic [15:0] ct, input logic [14:0] ss,
                             input logic [15:0] s2t, input logic [15:0] ph,
                             input logic [15:0] bp, input logic [15:0] pg);
    event_t ev;
    ev.cos_theta = ct;
    ev.sin_sq_theta = ss;
    ev.sin_two_theta = s2t;
    ev.decay_phi = ph;
    ev.pol_phi = bp;
    ev.pol_degree = pg;
    event_queue.push_back(ev);
    events_sent++;
  endtask

  task automatic wait_drained();
    wait (event_queue.size() == 0 && !s_axis_tvalid && weights_seen == events_sent);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) rho_regs[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < NumPhases; phase++) begin
      // Idle pattern: receiver-heavy gaps, then sender-heavy, then none.
      if (phase < 3) begin
        send_idle_pct = 9;  recv_idle_pct = 77;
      end else if (phase < 5) begin
        send_idle_pct = 77; recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;  recv_idle_pct = 0;
      end
      load_rho((phase == 0) ? 3 : (phase == 1) ? 1 : (phase == 2) ? 2 :
               (phase == 3) ? 0 : 3);

      if (phase == 0) begin
        // Polar-angle extremes, the last two with full polarization.
        queue_event(16'h7FFF, 15'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        queue_event(16'h8000, 15'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        queue_event(16'd0, 15'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0);
        queue_event(16'd0, 15'h7FFF, 16'h7FFF, 16'd0, 16'd0, 16'hFFFF);
        queue_event(16'd0, 15'h7FFF, 16'h8000, 16'd0, 16'd0, 16'hFFFF);
        // Every quadrant boundary and wrap point of both angles.
        for (int k = 0; k < 8; k++) begin
          queue_event(16'h4000, 15'h5A82, 16'h5A82, 16'(k * 16'h2000),
                      16'(16'hE000 - k * 16'h2000), 16'hFFFF);
        end
        queue_event(16'h5A82, 15'h4000, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h8000);
        queue_event(16'hA57E, 15'h4000, 16'h8001, 16'h8000, 16'hFFFF, 16'h0001);
        // Angles inconsistent with one another are used as given.
        queue_event(16'h7FFF, 15'h7FFF, 16'h7FFF, 16'h1234, 16'h4321, 16'hFFFF);
        queue_event(16'h8000, 15'h7FFF, 16'h8000, 16'h9ABC, 16'hCDEF, 16'hFFFF);
      end

      for (int n = 0; n < RandItems; n++) begin
        if ($urandom_range(3) != 0) begin
          // Physically consistent event: cos and sin from one polar angle.
          logic [15:0] th;
          longint c, s;
          th = 16'($urandom_range(16'h7FFF));
          c = turn_cosine(th >> 1) >>> 15;
          s = turn_sine(th >> 1) >>> 15;
          if (c > 32767) c = 32767;
          if (s > 32767) s = 32767;
          queue_event(16'(c), 15'((s * s) >> 15), 16'((2 * s * c) >> 15),
                      16'($urandom), 16'($urandom), pick_word());
        end else begin
          queue_event(pick_word(), 15'(pick_word()), pick_word(), pick_word(),
                      pick_word(), pick_word());
        end
      end
      wait_drained();
    end

    if (error_count == 0 && weight_queue.size() == 0) begin
      $display("** vector_meson_decay_angle_amplitude: PASSED **");
    end else begin
      $display("** vector_meson_decay_angle_amplitude: FAILED **");
    end
    $finish;
  end

endmodule
